>>> sv/ghp_pkg.sv
// ----------------------------------------------------------------------------
// ghp_pkg
// Shared types and constants for the generational handle pool.
// ----------------------------------------------------------------------------
package ghp_pkg;

  // defaults for the top-level parameters
  localparam int MAX_SLOTS_DEF  = 256;
  localparam int INDEX_BITS_DEF = 16;

  // fixed field widths
  localparam int HANDLE_W = 32;
  localparam int CFG_W    = 9;
  localparam int ENDED_W  = 9;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;

  // slot count after reset, before clamping to the pool size
  localparam int RESET_SLOTS = 256;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_CHECK   = 2'd2,
    KIND_ENDED   = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_INVALID   = 2'd1,
    STAT_NO_SLOT   = 2'd2,
    STAT_NO_ACTION = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } ghp_state_e;

  // free stack control
  typedef struct packed {
    logic clear;
    logic rd;
    logic pop;
    logic push;
  } stk_cmd_t;

  // slot table control
  typedef struct packed {
    logic clear;
    logic rd;
    logic wr;
  } tbl_cmd_t;

endpackage

>>> sv/ghp_req_if.sv
// ----------------------------------------------------------------------------
// ghp_req_if
// Request channel of the handle pool: valid/ready with the operation payload.
// ----------------------------------------------------------------------------
interface ghp_req_if;
  logic                         valid;
  logic                         ready;
  logic [ghp_pkg::KIND_W-1:0]   kind;
  logic [ghp_pkg::HANDLE_W-1:0] handle;
  logic                         loop_flag;
  logic                         source_ok;
  logic [ghp_pkg::ENDED_W-1:0]  ended_slot;

  modport source (output valid, kind, handle, loop_flag, source_ok, ended_slot,
                  input ready);
  modport sink (input valid, kind, handle, loop_flag, source_ok, ended_slot,
                output ready);
endinterface

>>> sv/ghp_rsp_if.sv
// ----------------------------------------------------------------------------
// ghp_rsp_if
// Response channel of the handle pool: valid/ready with the result payload.
// ----------------------------------------------------------------------------
interface ghp_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ghp_pkg::STATUS_W-1:0] status;
  logic [ghp_pkg::HANDLE_W-1:0] new_handle;
  logic                         handle_valid;

  modport source (output valid, status, new_handle, handle_valid, input ready);
  modport sink (input valid, status, new_handle, handle_valid, output ready);
endinterface

>>> sv/ghp_slot_table.sv
// ----------------------------------------------------------------------------
// ghp_slot_table
// Per-slot memory {generation, active, loops} with a clearing sweep.
// ----------------------------------------------------------------------------
module ghp_slot_table #(
  parameter int MAX_SLOTS = ghp_pkg::MAX_SLOTS_DEF,
  parameter int GEN_W     = ghp_pkg::HANDLE_W - ghp_pkg::INDEX_BITS_DEF,
  parameter int SIDX_W    = $clog2(MAX_SLOTS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ghp_pkg::tbl_cmd_t  cmd_i,
  input  logic [SIDX_W-1:0]  count_i,
  input  logic [SIDX_W-1:0]  rd_addr_i,
  input  logic [SIDX_W-1:0]  wr_addr_i,
  input  logic [GEN_W+1:0]   wr_data_i,
  output logic [GEN_W+1:0]   rd_data_o,
  output logic               busy_o
);

  logic [GEN_W+1:0]  mem [MAX_SLOTS+1];
  logic [GEN_W+1:0]  rd_q;
  logic              busy_q, busy_d;
  logic [SIDX_W-1:0] ptr_q, ptr_d;
  logic              we;
  logic [SIDX_W-1:0] wa;
  logic [GEN_W+1:0]  wd;

  // sweep from the slot count down to entry 0, writing zero
  always_comb begin
    busy_d = busy_q;
    ptr_d  = ptr_q;
    if (cmd_i.clear) begin
      busy_d = 1'b1;
      ptr_d  = count_i;
    end else if (busy_q) begin
      if (ptr_q == '0) begin
        busy_d = 1'b0;
      end else begin
        ptr_d = ptr_q - SIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      ptr_q  <= SIDX_W'(MAX_SLOTS);
    end else begin
      busy_q <= busy_d;
      ptr_q  <= ptr_d;
    end
  end

  assign we = busy_q || cmd_i.wr;
  assign wa = busy_q ? ptr_q : wr_addr_i;
  assign wd = busy_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;
  assign busy_o    = busy_q;

endmodule

>>> sv/ghp_free_stack.sv
// ----------------------------------------------------------------------------
// ghp_free_stack
// Free slot stack in memory; entries hold {generation, index}.
// Positions below the low-water mark were never pushed since the last clear
// and read as their initial value, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module ghp_free_stack #(
  parameter int MAX_SLOTS   = ghp_pkg::MAX_SLOTS_DEF,
  parameter int GEN_W       = ghp_pkg::HANDLE_W - ghp_pkg::INDEX_BITS_DEF,
  parameter int SIDX_W      = $clog2(MAX_SLOTS + 1),
  parameter int RESET_COUNT = ghp_pkg::RESET_SLOTS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ghp_pkg::stk_cmd_t       cmd_i,
  input  logic [SIDX_W-1:0]       count_i,
  input  logic [GEN_W+SIDX_W-1:0] push_data_i,
  output logic [GEN_W+SIDX_W-1:0] top_o,
  output logic                    empty_o,
  output logic                    full_o
);

  localparam int STK_AW = $clog2(MAX_SLOTS);
  localparam int ENT_W  = GEN_W + SIDX_W;

  logic [ENT_W-1:0]  mem [MAX_SLOTS];
  logic [ENT_W-1:0]  rd_q;
  logic [SIDX_W-1:0] fc_q, fc_d;
  logic [SIDX_W-1:0] low_q, low_d;
  logic [SIDX_W-1:0] fc_dec;
  logic [SIDX_W-1:0] count_q;
  logic [SIDX_W-1:0] fresh_idx;

  assign fc_dec = fc_q - SIDX_W'(1);

  always_comb begin
    fc_d  = fc_q;
    low_d = low_q;
    if (cmd_i.clear) begin
      fc_d  = count_i;
      low_d = count_i;
    end else if (cmd_i.pop) begin
      fc_d = fc_dec;
      if (fc_dec < low_q) begin
        low_d = fc_dec;
      end
    end else if (cmd_i.push) begin
      fc_d = fc_q + SIDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q    <= SIDX_W'(RESET_COUNT);
      low_q   <= SIDX_W'(RESET_COUNT);
      count_q <= SIDX_W'(RESET_COUNT);
    end else begin
      fc_q  <= fc_d;
      low_q <= low_d;
      if (cmd_i.clear) begin
        count_q <= count_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[fc_q[STK_AW-1:0]] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_q <= mem[fc_dec[STK_AW-1:0]];
    end
  end

  // untouched position p holds count - p, generation zero
  assign fresh_idx = count_q - fc_q + SIDX_W'(1);
  assign top_o     = (fc_q == low_q) ? {{GEN_W{1'b0}}, fresh_idx} : rd_q;
  assign empty_o   = (fc_q == '0);
  assign full_o    = (fc_q == SIDX_W'(MAX_SLOTS));

endmodule

>>> sv/generational_handle_pool_unit.sv
// ----------------------------------------------------------------------------
// generational_handle_pool_unit
// Pool of playback slots handed out as generation/index handles.
//
//   port         dir  transfer when       carries
//   req_i        in   valid && ready      kind, handle, loop_flag, source_ok,
//                                         ended_slot
//   rsp_o        out  valid && ready      status, new_handle, handle_valid
//   cfg_we_i     in   cfg_we_i high       slot_count in cfg_data_i
//
// Each request first does a registered read of the slot table and the free
// stack, then updates both and loads the result register.
// After reset the slot table is swept from entry MAX_SLOTS down to 0, after a
// slot count write from the new slot count down; requests are held off meanwhile.
// A result that is not taken holds the update back until rsp_o.ready; a new
// request is taken while the previous result still waits.
// ----------------------------------------------------------------------------
module generational_handle_pool_unit #(
  parameter int MAX_SLOTS  = ghp_pkg::MAX_SLOTS_DEF,
  parameter int INDEX_BITS = ghp_pkg::INDEX_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ghp_pkg::CFG_W-1:0] cfg_data_i,
  ghp_req_if.sink                   req_i,
  ghp_rsp_if.source                 rsp_o
);

  localparam int GEN_W     = ghp_pkg::HANDLE_W - INDEX_BITS;
  localparam int SIDX_W    = $clog2(MAX_SLOTS + 1);
  localparam int IDX_MAX   = (2 ** INDEX_BITS) - 1;
  localparam int LIMIT     = (MAX_SLOTS < IDX_MAX) ? MAX_SLOTS : IDX_MAX;
  localparam int RST_COUNT = (ghp_pkg::RESET_SLOTS < LIMIT) ? ghp_pkg::RESET_SLOTS : LIMIT;
  localparam int CW0       = (SIDX_W > INDEX_BITS) ? SIDX_W : INDEX_BITS;
  localparam int CW        = (CW0 > ghp_pkg::CFG_W) ? CW0 : ghp_pkg::CFG_W;

  ghp_pkg::ghp_state_e state_q, state_d;

  // request registers
  ghp_pkg::kind_e               kind_q;
  logic [ghp_pkg::HANDLE_W-1:0] handle_q;
  logic                         loop_q;
  logic                         src_q;
  logic [ghp_pkg::ENDED_W-1:0]  ended_q;
  logic [SIDX_W-1:0]            slot_addr_q;

  // result registers
  logic                         rsp_valid_q;
  ghp_pkg::status_e             status_q, status_d;
  logic [ghp_pkg::HANDLE_W-1:0] new_handle_q, new_handle_d;
  logic                         hvalid_q, hvalid_d;

  logic [SIDX_W-1:0] slot_count_q, slot_count_d;
  logic [CW-1:0]     cfg_ext;

  logic accept, out_free, done;

  ghp_pkg::stk_cmd_t       stk_cmd;
  ghp_pkg::tbl_cmd_t       tbl_cmd;
  logic [GEN_W+SIDX_W-1:0] stk_top, stk_push;
  logic                    stk_empty, stk_full;
  logic [GEN_W+1:0]        tbl_rd, tbl_wd;
  logic [SIDX_W-1:0]       tbl_wa, rd_addr;
  logic                    tbl_busy;

  logic [CW-1:0]         in_idx_ext, in_end_ext;
  logic [CW-1:0]         h_idx_ext, e_idx_ext, cnt_ext, top_ext;
  logic [GEN_W-1:0]      slot_gen, gen_inc, top_gen;
  logic                  slot_act, slot_loop;
  logic [SIDX_W-1:0]     top_idx;
  logic                  h_ok, e_ok, do_alloc, do_reclaim;

  // slot count write: zero becomes one, large values saturate
  always_comb begin
    cfg_ext = CW'(cfg_data_i);
    if (cfg_ext == '0) begin
      cfg_ext = CW'(1);
    end else if (cfg_ext > CW'(LIMIT)) begin
      cfg_ext = CW'(LIMIT);
    end
    slot_count_d = cfg_ext[SIDX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= SIDX_W'(RST_COUNT);
    end else if (cfg_we_i) begin
      slot_count_q <= slot_count_d;
    end
  end

  assign req_i.ready = (state_q == ghp_pkg::S_IDLE) && !tbl_busy && !cfg_we_i;
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !rsp_valid_q || rsp_o.ready;

  always_comb begin
    state_d = state_q;
    done    = 1'b0;
    case (state_q)
      ghp_pkg::S_IDLE: begin
        if (accept) begin
          state_d = ghp_pkg::S_EXEC;
        end
      end
      ghp_pkg::S_EXEC: begin
        if (out_free) begin
          done    = 1'b1;
          state_d = ghp_pkg::S_IDLE;
        end
      end
      default: state_d = ghp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ghp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // slot read address: handle index for release/check, slot number for ended
  assign in_idx_ext = CW'(req_i.handle[INDEX_BITS-1:0]);
  assign in_end_ext = CW'(req_i.ended_slot);
  assign rd_addr    = (req_i.kind == ghp_pkg::KIND_ENDED) ? in_end_ext[SIDX_W-1:0]
                                                          : in_idx_ext[SIDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q      <= ghp_pkg::kind_e'(req_i.kind);
      handle_q    <= req_i.handle;
      loop_q      <= req_i.loop_flag;
      src_q       <= req_i.source_ok;
      ended_q     <= req_i.ended_slot;
      slot_addr_q <= rd_addr;
    end
  end

  // decode of the read data
  assign slot_gen  = tbl_rd[GEN_W+1:2];
  assign slot_act  = tbl_rd[1];
  assign slot_loop = tbl_rd[0];
  assign gen_inc   = slot_gen + GEN_W'(1);
  assign top_gen   = stk_top[GEN_W+SIDX_W-1:SIDX_W];
  assign top_idx   = stk_top[SIDX_W-1:0];
  assign top_ext   = CW'(top_idx);

  assign h_idx_ext = CW'(handle_q[INDEX_BITS-1:0]);
  assign e_idx_ext = CW'(ended_q);
  assign cnt_ext   = CW'(slot_count_q);

  assign h_ok = (h_idx_ext != '0) && (h_idx_ext <= cnt_ext) && slot_act &&
                (slot_gen == handle_q[ghp_pkg::HANDLE_W-1:INDEX_BITS]);
  assign e_ok = (e_idx_ext != '0) && (e_idx_ext <= cnt_ext) && slot_act && !slot_loop;

  always_comb begin
    status_d     = ghp_pkg::STAT_NO_ACTION;
    new_handle_d = '0;
    hvalid_d     = 1'b0;
    do_alloc     = 1'b0;
    do_reclaim   = 1'b0;
    case (kind_q)
      ghp_pkg::KIND_ALLOC: begin
        if (!src_q) begin
          status_d = ghp_pkg::STAT_INVALID;
        end else if (stk_empty) begin
          status_d = ghp_pkg::STAT_NO_SLOT;
        end else begin
          status_d     = ghp_pkg::STAT_OK;
          do_alloc     = 1'b1;
          new_handle_d = {top_gen, top_ext[INDEX_BITS-1:0]};
        end
      end
      ghp_pkg::KIND_RELEASE, ghp_pkg::KIND_CHECK: begin
        if (h_ok) begin
          status_d   = ghp_pkg::STAT_OK;
          hvalid_d   = 1'b1;
          do_reclaim = (kind_q == ghp_pkg::KIND_RELEASE);
        end else begin
          status_d = ghp_pkg::STAT_INVALID;
        end
      end
      ghp_pkg::KIND_ENDED: begin
        if (e_ok) begin
          status_d   = ghp_pkg::STAT_OK;
          do_reclaim = 1'b1;
        end
      end
      default: status_d = ghp_pkg::STAT_NO_ACTION;
    endcase
  end

  // free stack
  assign stk_cmd.clear = cfg_we_i;
  assign stk_cmd.rd    = accept;
  assign stk_cmd.pop   = done && do_alloc;
  assign stk_cmd.push  = done && do_reclaim && !stk_full;
  assign stk_push      = {gen_inc, slot_addr_q};

  ghp_free_stack #(
    .MAX_SLOTS  (MAX_SLOTS),
    .GEN_W      (GEN_W),
    .SIDX_W     (SIDX_W),
    .RESET_COUNT(RST_COUNT)
  ) u_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (stk_cmd),
    .count_i    (slot_count_d),
    .push_data_i(stk_push),
    .top_o      (stk_top),
    .empty_o    (stk_empty),
    .full_o     (stk_full)
  );

  // slot table: allocate marks active, reclaim bumps generation and clears active
  assign tbl_cmd.clear = cfg_we_i;
  assign tbl_cmd.rd    = accept;
  assign tbl_cmd.wr    = done && (do_alloc || do_reclaim);
  assign tbl_wa        = do_alloc ? top_idx : slot_addr_q;
  assign tbl_wd        = do_alloc ? {top_gen, 1'b1, loop_q} : {gen_inc, 1'b0, slot_loop};

  ghp_slot_table #(
    .MAX_SLOTS(MAX_SLOTS),
    .GEN_W    (GEN_W),
    .SIDX_W   (SIDX_W)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (tbl_cmd),
    .count_i  (slot_count_d),
    .rd_addr_i(rd_addr),
    .wr_addr_i(tbl_wa),
    .wr_data_i(tbl_wd),
    .rd_data_o(tbl_rd),
    .busy_o   (tbl_busy)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (done) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      status_q     <= status_d;
      new_handle_q <= new_handle_d;
      hvalid_q     <= hvalid_d;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.new_handle   = new_handle_q;
  assign rsp_o.handle_valid = hvalid_q;

endmodule

>>> dv/ghp_pool_checker.sv
// ----------------------------------------------------------------------------
// ghp_pool_checker
// Watches the request, response and slot count ports of the handle pool,
// keeps its own copy of the slots and the free stack, works out the result
// of every request transfer and compares each response transfer against the
// oldest result still outstanding.
// ----------------------------------------------------------------------------
module ghp_pool_checker
  import ghp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  ghp_req_if               req_i,
  ghp_rsp_if               rsp_i,
  output int               mismatch_o,
  output int               outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS       = MAX_SLOTS_DEF;
  localparam int IDX_W       = INDEX_BITS_DEF;
  localparam int GEN_W       = HANDLE_W - IDX_W;
  localparam int SLOT_LIM    = (SLOTS < (1 << IDX_W) - 1) ? SLOTS : (1 << IDX_W) - 1;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    status_e             status;
    logic [HANDLE_W-1:0] new_handle;
    logic                handle_valid;
  } pool_rsp_t;

  int unsigned      active_slots;
  int unsigned      free_depth;
  int unsigned      free_stack [SLOTS];
  logic [GEN_W-1:0] slot_gen   [SLOTS+1];
  bit               slot_busy  [SLOTS+1];
  bit               slot_loop  [SLOTS+1];
  pool_rsp_t        expected_q [$];

  function automatic void refill_pool();
    for (int i = 0; i <= SLOTS; i++) begin
      slot_gen[i]  = '0;
      slot_busy[i] = 1'b0;
      slot_loop[i] = 1'b0;
    end
    // slot 1 ends up on top of the stack
    for (int i = 0; i < SLOTS; i++) begin
      free_stack[i] = (i < active_slots) ? active_slots - i : 0;
    end
    free_depth = active_slots;
  endfunction

  function automatic void set_slot_count(input logic [CFG_W-1:0] value);
    int unsigned n;
    n = value;
    if (n == 0) n = 1;
    if (n > SLOT_LIM) n = SLOT_LIM;
    active_slots = n;
    refill_pool();
  endfunction

  function automatic void free_slot(input int unsigned idx);
    slot_busy[idx] = 1'b0;
    // generation rolls over to zero past its top value
    slot_gen[idx] = slot_gen[idx] + 1'b1;
    if (free_depth < SLOTS) begin
      free_stack[free_depth] = idx;
      free_depth++;
    end
  endfunction

  function automatic bit handle_live(input logic [HANDLE_W-1:0] h);
    int unsigned idx;
    idx = h[IDX_W-1:0];
    if (idx == 0 || idx > active_slots) return 1'b0;
    return slot_busy[idx] && (slot_gen[idx] == h[HANDLE_W-1:IDX_W]);
  endfunction

  function automatic pool_rsp_t predict_op(input kind_e kind,
                                           input logic [HANDLE_W-1:0] h,
                                           input logic loop_flag,
                                           input logic source_ok,
                                           input logic [ENDED_W-1:0] ended_slot);
    pool_rsp_t r;
    int unsigned idx;
    r.status       = STAT_NO_ACTION;
    r.new_handle   = '0;
    r.handle_valid = 1'b0;
    case (kind)
      KIND_ALLOC: begin
        if (!source_ok) begin
          r.status = STAT_INVALID;
        end else if (free_depth == 0) begin
          r.status = STAT_NO_SLOT;
        end else begin
          free_depth--;
          idx            = free_stack[free_depth];
          slot_busy[idx] = 1'b1;
          slot_loop[idx] = loop_flag;
          r.new_handle   = {slot_gen[idx], IDX_W'(idx)};
          r.status       = STAT_OK;
        end
      end
      KIND_RELEASE, KIND_CHECK: begin
        if (handle_live(h)) begin
          r.status       = STAT_OK;
          r.handle_valid = 1'b1;
          if (kind == KIND_RELEASE) free_slot(h[IDX_W-1:0]);
        end else begin
          r.status = STAT_INVALID;
        end
      end
      default: begin
        idx = ended_slot;
        // looping or idle slots ignore the end of playback
        if (idx != 0 && idx <= active_slots && slot_busy[idx] && !slot_loop[idx]) begin
          free_slot(idx);
          r.status = STAT_OK;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pool_rsp_t seen;
    pool_rsp_t want;
    if (!rst_ni) begin
      expected_q.delete();
      mismatch_o = 0;
      set_slot_count(CFG_W'(RESET_SLOTS));
    end else begin
      // response side first: a result never belongs to a same-edge request
      if (rsp_i.valid && rsp_i.ready) begin
        seen.status       = status_e'(rsp_i.status);
        seen.new_handle   = rsp_i.new_handle;
        seen.handle_valid = rsp_i.handle_valid;
        if (expected_q.size() == 0) begin
          if (mismatch_o < MAX_REPORTS)
            $display("%t: result with nothing outstanding: status=%0d handle=%h valid=%b",
                     $realtime, seen.status, seen.new_handle, seen.handle_valid);
          mismatch_o++;
        end else begin
          want = expected_q.pop_front();
          if (seen !== want) begin
            if (mismatch_o < MAX_REPORTS)
              $display({"%t: result mismatch: expected status=%0d handle=%h valid=%b,",
                        " got status=%0d handle=%h valid=%b"},
                       $realtime, want.status, want.new_handle, want.handle_valid,
                       seen.status, seen.new_handle, seen.handle_valid);
            mismatch_o++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        expected_q.push_back(predict_op(kind_e'(req_i.kind), req_i.handle, req_i.loop_flag,
                                        req_i.source_ok, req_i.ended_slot));
      end
      if (cfg_we_i) set_slot_count(cfg_data_i);
    end
    outstanding_o = expected_q.size();
  end

endmodule

>>> dv/tb_generational_handle_pool_unit.sv
// ----------------------------------------------------------------------------
// tb_generational_handle_pool_unit
// Drives the handle pool with a directed opening, random phases under several
// slot counts (with random stalls on both channels and one long response
// hold-off) and a closing run that recycles one slot through a few generations.
// Results are checked by ghp_pool_checker.
// ----------------------------------------------------------------------------
module tb_generational_handle_pool_unit
  import ghp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_W       = INDEX_BITS_DEF;
  localparam int GEN_W       = HANDLE_W - IDX_W;
  localparam int TAIL_GENS   = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 155;
  localparam int HOLD_PHASE  = 6;
  localparam logic [CFG_W-1:0] SLOT_PLAN [8] = '{9'd511, 9'd2, 9'd256, 9'd17,
                                                 9'd0, 9'd300, 9'd64, 9'd5};

  typedef struct packed {
    kind_e               kind;
    logic [HANDLE_W-1:0] handle;
    logic                loop_flag;
    logic                source_ok;
    logic [ENDED_W-1:0]  ended_slot;
  } pool_req_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;
  int               mismatches;
  int               outstanding;
  bit               quiet_tail;
  bit               hold_rq;
  int               tx_calm;
  logic [HANDLE_W-1:0] live_q [$];

  ghp_req_if req_if ();
  ghp_rsp_if rsp_if ();

  generational_handle_pool_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  ghp_pool_checker pool_chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_data_i    (cfg_data),
    .req_i         (req_if),
    .rsp_i         (rsp_if),
    .mismatch_o    (mismatches),
    .outstanding_o (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // handles handed out feed later release, check and ended traffic
  always @(posedge clk) begin
    if (rsp_if.valid && rsp_if.ready && rsp_if.status == STAT_OK &&
        rsp_if.new_handle != '0) begin
      live_q.push_back(rsp_if.new_handle);
      if (live_q.size() > 64) void'(live_q.pop_front());
    end
  end

  function automatic pool_req_t mk_op(input kind_e kind, input logic [HANDLE_W-1:0] h,
                                      input logic loop_flag, input logic source_ok,
                                      input logic [ENDED_W-1:0] ended_slot);
    pool_req_t op;
    op.kind       = kind;
    op.handle     = h;
    op.loop_flag  = loop_flag;
    op.source_ok  = source_ok;
    op.ended_slot = ended_slot;
    return op;
  endfunction

  function automatic pool_req_t pick_op();
    pool_req_t   op;
    int unsigned roll;
    int unsigned pos;
    op.kind       = kind_e'($urandom_range(0, 3));
    op.handle     = $urandom;
    op.loop_flag  = 1'($urandom_range(0, 1));
    op.source_ok  = 1'($urandom_range(0, 1));
    op.ended_slot = ENDED_W'($urandom_range(0, 511));
    roll          = $urandom_range(0, 99);
    // top 15 percent stays raw noise
    if (roll < 35) begin
      op.kind      = KIND_ALLOC;
      op.source_ok = ($urandom_range(0, 9) != 0);
    end else if (roll < 85) begin
      op.kind = (roll < 60) ? KIND_RELEASE : (roll < 75) ? KIND_CHECK : KIND_ENDED;
      if (live_q.size() != 0 && $urandom_range(0, 4) != 0) begin
        pos           = $urandom_range(0, live_q.size() - 1);
        op.handle     = live_q[pos];
        op.ended_slot = ENDED_W'(live_q[pos][IDX_W-1:0]);
        if (op.kind == KIND_RELEASE) live_q.delete(pos);
      end else begin
        op.handle     = {GEN_W'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 300))};
        op.ended_slot = ENDED_W'($urandom_range(0, 300));
      end
    end
    return op;
  endfunction

  task automatic send_op(input pool_req_t op);
    req_if.valid      <= 1'b1;
    req_if.kind       <= op.kind;
    req_if.handle     <= op.handle;
    req_if.loop_flag  <= op.loop_flag;
    req_if.source_ok  <= op.source_ok;
    req_if.ended_slot <= op.ended_slot;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
    if (tx_calm > 0) begin
      tx_calm--;
    end else if (!quiet_tail && $urandom_range(0, 49) == 0) begin
      tx_calm = $urandom_range(30, 150);
    end else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_slots(input logic [CFG_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    live_q.delete();
  endtask

  // response side: random stall bursts, calm stretches, one long hold-off
  initial begin : rsp_side
    int stall_left;
    int calm_left;
    bit calm;
    rsp_if.ready = 1'b0;
    stall_left   = 0;
    calm_left    = 0;
    calm         = 1'b0;
    forever begin
      @(posedge clk);
      if (calm_left == 0) begin
        calm      = ($urandom_range(0, 2) == 0);
        calm_left = $urandom_range(40, 250);
      end else begin
        calm_left--;
      end
      if (hold_rq) begin
        hold_rq    = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else if (!quiet_tail && !calm && $urandom_range(0, 9) == 0) begin
        rsp_if.ready <= 1'b0;
        stall_left = $urandom_range(1, 19) - 1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_data          = '0;
    req_if.valid      = 1'b0;
    req_if.kind       = KIND_ALLOC;
    req_if.handle     = '0;
    req_if.loop_flag  = 1'b0;
    req_if.source_ok  = 1'b0;
    req_if.ended_slot = '0;
    quiet_tail        = 1'b0;
    hold_rq           = 1'b0;
    tx_calm           = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full pool after reset
    send_op(mk_op(KIND_ALLOC,   32'h0000_0000, 1'b0, 1'b0, 9'd0));    // bad source
    send_op(mk_op(KIND_ALLOC,   32'hFFFF_FFFF, 1'b0, 1'b1, 9'h1FF));
    send_op(mk_op(KIND_ALLOC,   32'h0000_0000, 1'b1, 1'b1, 9'd0));    // looping slot 2
    send_op(mk_op(KIND_CHECK,   32'h0000_0001, 1'b1, 1'b1, 9'd0));
    send_op(mk_op(KIND_CHECK,   32'h0001_0001, 1'b0, 1'b0, 9'd0));    // wrong generation
    send_op(mk_op(KIND_CHECK,   32'h0000_0000, 1'b0, 1'b0, 9'd0));
    send_op(mk_op(KIND_CHECK,   32'h0000_0101, 1'b0, 1'b0, 9'd0));    // past slot count
    send_op(mk_op(KIND_CHECK,   32'h0000_0003, 1'b0, 1'b0, 9'd0));    // idle slot
    send_op(mk_op(KIND_RELEASE, 32'h0000_0001, 1'b0, 1'b0, 9'd0));
    send_op(mk_op(KIND_RELEASE, 32'h0000_0001, 1'b0, 1'b0, 9'd0));    // now stale
    send_op(mk_op(KIND_ENDED,   32'h0000_0000, 1'b0, 1'b0, 9'd2));
    send_op(mk_op(KIND_ENDED,   32'h0000_0000, 1'b0, 1'b0, 9'd0));
    send_op(mk_op(KIND_ENDED,   32'h0000_0000, 1'b0, 1'b0, 9'd257));
    send_op(mk_op(KIND_ENDED,   32'hFFFF_FFFF, 1'b1, 1'b1, 9'd511));
    send_op(mk_op(KIND_ENDED,   32'h0000_0000, 1'b0, 1'b0, 9'd5));
    send_op(mk_op(KIND_ALLOC,   32'h0000_0000, 1'b0, 1'b1, 9'd0));
    send_op(mk_op(KIND_ENDED,   32'h0000_0000, 1'b0, 1'b0, 9'd1));
    send_op(mk_op(KIND_RELEASE, 32'h0000_0002, 1'b0, 1'b0, 9'd0));
    send_op(mk_op(KIND_CHECK,   32'hFFFF_FFFF, 1'b0, 1'b0, 9'd0));

    // zero slot count means one slot: exhaust it
    drain();
    write_slots(9'd0);
    send_op(mk_op(KIND_ALLOC,   32'h0000_0000, 1'b0, 1'b1, 9'd0));
    send_op(mk_op(KIND_ALLOC,   32'h0000_0000, 1'b1, 1'b1, 9'd0));
    send_op(mk_op(KIND_CHECK,   32'h0000_0002, 1'b0, 1'b0, 9'd0));
    send_op(mk_op(KIND_RELEASE, 32'h0000_0001, 1'b0, 1'b0, 9'd0));
    send_op(mk_op(KIND_ALLOC,   32'h0000_0000, 1'b0, 1'b1, 9'd0));

    foreach (SLOT_PLAN[p]) begin
      drain();
      write_slots(SLOT_PLAN[p]);
      if (p == HOLD_PHASE) hold_rq = 1'b1;
      repeat (PHASE_ITEMS) send_op(pick_op());
    end

    // one slot recycled through a few generations
    drain();
    quiet_tail = 1'b1;
    write_slots(9'd1);
    for (int g = 0; g < TAIL_GENS; g++) begin
      send_op(mk_op(KIND_ALLOC, $urandom, 1'($urandom_range(0, 1)), 1'b1,
                    ENDED_W'($urandom_range(0, 511))));
      send_op(mk_op(KIND_RELEASE, {GEN_W'(g), IDX_W'(1)}, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), ENDED_W'($urandom_range(0, 511))));
    end
    send_op(mk_op(KIND_ALLOC,   32'h0000_0000, 1'b0, 1'b1, 9'd0));
    send_op(mk_op(KIND_CHECK,   {{GEN_W{1'b1}}, IDX_W'(1)}, 1'b0, 1'b0, 9'd0));
    send_op(mk_op(KIND_RELEASE, 32'h0000_0001, 1'b0, 1'b0, 9'd0));
    drain();

    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_generational_handle_pool_unit: PASS");
    end else begin
      $display("tb_generational_handle_pool_unit: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #25ms;
    $display("tb_generational_handle_pool_unit: FAIL");
    $finish;
  end

endmodule
